[design/m4i_pkg.sv]
// ----------------------------------------------------------------------------
// m4i_pkg: shared definitions of the 4x4 matrix inverse unit
// Widths of the exact integer intermediates and the control word of the
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none
package m4i_pkg;
	localparam int ELEM_W        = 32;
	localparam int LIMB_W        = 32;
	localparam int PROD_W        = 2 * (LIMB_W + 1);
	localparam int MINOR_W       = 65;
	localparam int COF_W         = 99;
	localparam int DET_W         = 133;
	localparam int OP_W          = 4 * LIMB_W;
	localparam int IDX_W         = 4;
	localparam int FRAC_BITS_DEF = 16;

	typedef struct packed {
		logic       mul_en;
		logic       acc_en;
		logic       clr;
		logic       neg;
		logic       top;
		logic [1:0] limb;
	} mac_ctl_t;

	// Index n (0..2) of the list 0..3 with x removed.
	function automatic logic [1:0] excl(input logic [1:0] x, input logic [1:0] n);
		logic [1:0] r;
		r = (n < x) ? n : n + 2'd1;
		return r;
	endfunction
endpackage
`default_nettype wire

[design/m4i_in_if.sv]
// ----------------------------------------------------------------------------
// m4i_in_if: element request channel
// Carries one signed matrix element per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface m4i_in_if;
	logic                           valid;
	logic                           ready;
	logic signed [m4i_pkg::ELEM_W-1:0] element_value;
	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface
`default_nettype wire

[design/m4i_out_if.sv]
// ----------------------------------------------------------------------------
// m4i_out_if: result request channel
// Carries one inverse element with its index and status flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface m4i_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [m4i_pkg::ELEM_W-1:0] result_value;
	logic [m4i_pkg::IDX_W-1:0]         result_index;
	logic                              singular;
	logic                              saturated;
	logic                              last_of_run;
	modport source (output valid, output result_value, output result_index,
		output singular, output saturated, output last_of_run, input ready);
	modport sink (input valid, input result_value, input result_index,
		input singular, input saturated, input last_of_run, output ready);
endinterface
`default_nettype wire

[design/m4i_mac.sv]
// ----------------------------------------------------------------------------
// m4i_mac: shared multiply-accumulate unit
// A 33x33 signed multiply of an element by one limb of a wide operand,
// registered, then a shifted add or subtract into the wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module m4i_mac (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire m4i_pkg::mac_ctl_t                  ctl,
	input  wire logic signed [m4i_pkg::ELEM_W-1:0]  a,
	input  wire logic [m4i_pkg::LIMB_W-1:0]         b,
	output logic signed [m4i_pkg::DET_W-1:0]        acc
);
	localparam int PW = m4i_pkg::PROD_W;
	localparam int DW = m4i_pkg::DET_W;

	logic signed [m4i_pkg::ELEM_W:0] a_ext;
	logic signed [m4i_pkg::LIMB_W:0] b_ext;
	logic signed [PW-1:0]            prod_s1;
	logic [DW-1:0]                   term;
	logic [DW-1:0]                   base;
	logic signed [DW-1:0]            acc_q;

	assign a_ext = {a[m4i_pkg::ELEM_W-1], a};
	assign b_ext = {ctl.top & b[m4i_pkg::LIMB_W-1], b};
	assign term  = {{(DW-PW){prod_s1[PW-1]}}, prod_s1} << {ctl.limb, 5'b00000};
	assign base  = ctl.clr ? '0 : acc_q;
	assign acc   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.neg ? signed'(base - term) : signed'(base + term);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= a_ext * b_ext;
		end
	end
endmodule
`default_nettype wire

[design/m4i_div.sv]
// ----------------------------------------------------------------------------
// m4i_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, quotient shifted into
// the numerator register.
// ----------------------------------------------------------------------------
`default_nettype none
module m4i_div #(
	parameter int NUM_W = 131
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire logic [NUM_W-1:0]              num,
	input  wire logic [m4i_pkg::DET_W-1:0]     den,
	output logic                               busy,
	output logic [NUM_W-1:0]                   quot
);
	localparam int DW  = m4i_pkg::DET_W;
	localparam int CW  = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] nq_q;
	logic [DW-1:0]    rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DW:0]      rem_sh;
	logic [DW+1:0]    diff;

	assign rem_sh = {rem_q, nq_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den};
	assign busy   = busy_q;
	assign quot   = nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW-1:0];
				nq_q  <= {nq_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				nq_q  <= {nq_q[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

[design/matrix4_inverse_unit.sv]
// ----------------------------------------------------------------------------
// matrix4_inverse_unit: 4x4 fixed-point matrix inverse
// Loads 16 row-major elements, forms exact cofactors and the determinant
// on a shared multiply-accumulate unit, then divides each adjugate element
// by the determinant on a serial divider.
// ----------------------------------------------------------------------------
// Channel   Role    Payload
// element   sink    element_value
// result    source  result_value, result_index, singular, saturated, last_of_run
//
// Elements are taken only in the load state. After the sixteenth, the cofactor and
// determinant sequence runs on the multiply-accumulate unit, and each result is
// then formed by the serial divider.
// A singular matrix skips the divider; unstalled, it emits one result per cycle.
// Reset clears the load count and the sequencer; no element is kept.
// A stalled result holds the block before the next division.
`default_nettype none
module matrix4_inverse_unit #(
	parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
	input  wire    clk,
	input  wire    arst_n,
	m4i_in_if.sink   element,
	m4i_out_if.source result
);
	localparam int EW    = m4i_pkg::ELEM_W;
	localparam int MW    = m4i_pkg::MINOR_W;
	localparam int CW    = m4i_pkg::COF_W;
	localparam int DW    = m4i_pkg::DET_W;
	localparam int OW    = m4i_pkg::OP_W;
	localparam int NUM_W = CW + 2 * FRAC_BITS;

	typedef enum logic [3:0] {
		S_LOAD, S_FETCH_B, S_FETCH_A, S_MUL, S_ACC, S_NEXT, S_CHECK,
		S_DIV_INIT, S_DIV, S_EMIT
	} state_t;

	localparam logic [1:0] CA_IDX [6] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
	localparam logic [1:0] CB_IDX [6] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};

	state_t                 state_q;
	logic [3:0]             load_cnt_q;
	logic [3:0]             k_q;
	logic [3:0]             op_q;
	logic [1:0]             limb_q;
	logic [1:0]             top_limb_q;
	logic                   det_ph_q;
	logic                   sing_q;
	logic                   dneg_q;
	logic                   qneg_q;
	logic signed [EW-1:0]   elem_q [16];
	logic signed [MW-1:0]   minor_q [3];
	logic signed [CW-1:0]   cof_q [16];
	logic signed [DW-1:0]   det_q;
	logic [DW-1:0]          dmag_q;
	logic [OW-1:0]          bop_q;
	logic signed [EW-1:0]   aop_q;
	logic                   out_valid_q;
	logic signed [EW-1:0]   out_value_q;
	logic [3:0]             out_index_q;
	logic                   out_sing_q;
	logic                   out_sat_q;
	logic                   out_last_q;

	logic [1:0]             r_sel;
	logic [1:0]             c_sel;
	logic [2:0]             op_lo;
	logic [1:0]             mi_sel;
	logic [3:0]             rd_addr;
	logic signed [EW-1:0]   elem_rd;
	logic [3:0]             cof_addr;
	logic signed [CW-1:0]   cof_rd;
	logic [CW-1:0]          cof_mag;
	logic [NUM_W-1:0]       div_num;
	logic                   div_start;
	logic                   div_busy;
	logic [NUM_W-1:0]       quot;
	logic                   q_high;
	logic [EW-1:0]          q_val;
	logic                   q_sat;
	logic                   emit_go;
	logic                   grp_first;
	m4i_pkg::mac_ctl_t      mac_ctl;
	logic signed [DW-1:0]   acc;

	assign r_sel  = k_q[3:2];
	assign c_sel  = k_q[1:0];
	assign op_lo  = op_q[2:0];
	assign mi_sel = 2'(op_q - 4'd6);

	always_comb begin
		rd_addr = '0;
		if (det_ph_q) begin
			rd_addr = {op_q[1:0], 2'b00};
		end else if (state_q == S_FETCH_B) begin
			rd_addr = {m4i_pkg::excl(r_sel, 2'd2),
				m4i_pkg::excl(c_sel, CB_IDX[(op_lo > 3'd5) ? 3'd0 : op_lo])};
		end else if (op_q < 4'd6) begin
			rd_addr = {m4i_pkg::excl(r_sel, 2'd1),
				m4i_pkg::excl(c_sel, CA_IDX[(op_lo > 3'd5) ? 3'd0 : op_lo])};
		end else begin
			rd_addr = {m4i_pkg::excl(r_sel, 2'd0), m4i_pkg::excl(c_sel, mi_sel)};
		end
	end
	assign elem_rd = elem_q[rd_addr];

	assign cof_addr = (state_q == S_DIV_INIT) ? {k_q[1:0], k_q[3:2]} : {op_q[1:0], 2'b00};
	assign cof_rd   = cof_q[cof_addr];
	assign cof_mag  = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
	assign div_num  = {cof_mag, {(2 * FRAC_BITS){1'b0}}};
	assign div_start = (state_q == S_DIV_INIT);

	assign grp_first = det_ph_q ? (op_q == 4'd0)
		: (op_q == 4'd0 || op_q == 4'd2 || op_q == 4'd4 || op_q == 4'd6);

	always_comb begin
		mac_ctl        = '0;
		mac_ctl.mul_en = (state_q == S_MUL);
		mac_ctl.acc_en = (state_q == S_ACC);
		mac_ctl.clr    = grp_first && (limb_q == 2'd0);
		mac_ctl.top    = (limb_q == top_limb_q);
		mac_ctl.limb   = limb_q;
		if (det_ph_q) begin
			mac_ctl.neg = 1'b0;
		end else if (op_q < 4'd6) begin
			mac_ctl.neg = op_q[0];
		end else begin
			mac_ctl.neg = (op_q == 4'd7) ^ r_sel[0] ^ c_sel[0];
		end
	end

	m4i_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (aop_q),
		.b      (bop_q[limb_q*32 +: 32]),
		.acc    (acc)
	);

	m4i_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dmag_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign q_high = |quot[NUM_W-1:EW];
	always_comb begin
		if (!qneg_q) begin
			q_sat = q_high || quot[EW-1];
			q_val = q_sat ? {1'b0, {(EW-1){1'b1}}} : quot[EW-1:0];
		end else begin
			q_sat = q_high || (quot[EW-1:0] > {1'b1, {(EW-1){1'b0}}});
			q_val = q_sat ? {1'b1, {(EW-1){1'b0}}} : EW'(-quot[EW-1:0]);
		end
	end

	assign emit_go       = !out_valid_q || result.ready;
	assign element.ready = (state_q == S_LOAD);

	assign result.valid        = out_valid_q;
	assign result.result_value = out_value_q;
	assign result.result_index = out_index_q;
	assign result.singular     = out_sing_q;
	assign result.saturated    = out_sat_q;
	assign result.last_of_run  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			k_q         <= '0;
			op_q        <= '0;
			limb_q      <= '0;
			top_limb_q  <= '0;
			det_ph_q    <= 1'b0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (element.valid) begin
						elem_q[load_cnt_q] <= element.element_value;
						load_cnt_q         <= load_cnt_q + 1'b1;
						if (load_cnt_q == 4'd15) begin
							k_q      <= '0;
							op_q     <= '0;
							det_ph_q <= 1'b0;
							state_q  <= S_FETCH_B;
						end
					end
				end
				S_FETCH_B: begin
					if (det_ph_q) begin
						bop_q      <= {{(OW-CW){cof_rd[CW-1]}}, cof_rd};
						top_limb_q <= 2'd3;
					end else if (op_q < 4'd6) begin
						bop_q      <= {{(OW-EW){elem_rd[EW-1]}}, elem_rd};
						top_limb_q <= 2'd0;
					end else begin
						bop_q      <= {{(OW-MW){minor_q[mi_sel][MW-1]}}, minor_q[mi_sel]};
						top_limb_q <= 2'd2;
					end
					state_q <= S_FETCH_A;
				end
				S_FETCH_A: begin
					aop_q   <= elem_rd;
					limb_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (limb_q == top_limb_q) begin
						state_q <= S_NEXT;
					end else begin
						limb_q  <= limb_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_NEXT: begin
					if (det_ph_q) begin
						if (op_q == 4'd3) begin
							det_q   <= acc;
							state_q <= S_CHECK;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_FETCH_B;
						end
					end else begin
						if (op_q < 4'd6 && op_q[0]) begin
							minor_q[op_q[2:1]] <= acc[MW-1:0];
						end
						state_q <= S_FETCH_B;
						if (op_q == 4'd8) begin
							cof_q[k_q] <= acc[CW-1:0];
							op_q       <= '0;
							if (k_q == 4'd15) begin
								det_ph_q <= 1'b1;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end else begin
							op_q <= op_q + 1'b1;
						end
					end
				end
				S_CHECK: begin
					det_ph_q <= 1'b0;
					k_q      <= '0;
					sing_q   <= (det_q == '0);
					dneg_q   <= det_q[DW-1];
					dmag_q   <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
					state_q  <= (det_q == '0) ? S_EMIT : S_DIV_INIT;
				end
				S_DIV_INIT: begin
					qneg_q  <= cof_rd[CW-1] ^ dneg_q;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						out_index_q <= k_q;
						out_sing_q  <= sing_q;
						out_last_q  <= (k_q == 4'd15);
						if (sing_q) begin
							out_value_q <= (k_q[3:2] == k_q[1:0])
								? signed'(EW'(1) << FRAC_BITS) : '0;
							out_sat_q   <= 1'b0;
						end else begin
							out_value_q <= q_val;
							out_sat_q   <= q_sat;
						end
						if (k_q == 4'd15) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= sing_q ? S_EMIT : S_DIV_INIT;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the 4x4 fixed-point matrix inverse unit
// Feeds whole matrices as element requests. On each accepted sixteenth
// element it predicts the inverse from exact wide cofactors. Each result
// request is compared with the oldest prediction. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC   = m4i_pkg::FRAC_BITS_DEF;
	localparam int LIMIT  = 400000;
	localparam int IDLE_PCT = 13;

	typedef enum int {MAT_WIDE, MAT_SMALL, MAT_DIAG, MAT_SINGULAR} mat_kind_t;

	typedef struct {
		logic signed [m4i_pkg::ELEM_W-1:0] value;
		logic [m4i_pkg::IDX_W-1:0]         index;
		logic                              singular;
		logic                              saturated;
		logic                              last;
	} inv_elem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	m4i_in_if  element();
	m4i_out_if result();

	matrix4_inverse_unit u_top (.clk(clk), .arst_n(arst_n), .element(element), .result(result));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic signed [m4i_pkg::ELEM_W-1:0] pending_elems[$];
	inv_elem_t                         inverse_due[$];
	logic signed [m4i_pkg::ELEM_W-1:0] loaded[16];
	int load_pos = 0;
	int cycles = 0;
	int errors = 0;
	int matrices = 0;
	int singular_seen = 0;
	int clipped_seen = 0;
	bit calm = 1'b0;

	function automatic logic signed [255:0] cofactor(int r, int c);
		int rr[3], cc[3];
		int n, m, i;
		logic signed [255:0] e[3][3];
		logic signed [255:0] m0, m1, m2, s;
		n = 0;
		m = 0;
		for (i = 0; i < 4; i++) begin
			if (i != r) begin
				rr[n] = i;
				n++;
			end
			if (i != c) begin
				cc[m] = i;
				m++;
			end
		end
		for (i = 0; i < 9; i++) e[i/3][i%3] = loaded[rr[i/3]*4 + cc[i%3]];
		m0 = e[1][1]*e[2][2] - e[1][2]*e[2][1];
		m1 = e[1][0]*e[2][2] - e[1][2]*e[2][0];
		m2 = e[1][0]*e[2][1] - e[1][1]*e[2][0];
		s = e[0][0]*m0 - e[0][1]*m1 + e[0][2]*m2;
		return ((r + c) % 2 == 1) ? -s : s;
	endfunction

	task automatic predict_inverse();
		logic signed [255:0] det, a;
		logic [255:0] dmag, num, q;
		inv_elem_t x;
		bit neg;
		int k;
		det = 0;
		for (k = 0; k < 4; k++) det += loaded[k*4] * cofactor(k, 0);
		dmag = det[255] ? -det : det;
		matrices++;
		if (det == 0) singular_seen++;
		for (k = 0; k < 16; k++) begin
			x.index = k[m4i_pkg::IDX_W-1:0];
			x.last = (k == 15);
			x.singular = (det == 0);
			x.saturated = 1'b0;
			if (det == 0) begin
				x.value = ((k >> 2) == (k & 3)) ? (32'sd1 <<< FRAC) : 32'sd0;
			end else begin
				a = cofactor(k & 3, k >> 2);
				neg = a[255] != det[255];
				num = (a[255] ? -a : a) << (2*FRAC);
				q = num / dmag;
				if (!neg) begin
					x.saturated = q > 256'h7FFFFFFF;
					x.value = x.saturated ? 32'h7FFFFFFF : q[31:0];
				end else begin
					x.saturated = q > 256'h80000000;
					x.value = x.saturated ? 32'h80000000 : -q[31:0];
				end
				if (x.saturated) clipped_seen++;
			end
			inverse_due.push_back(x);
		end
	endtask

	// Element driver.
	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			element.valid <= 1'b0;
			element.element_value <= '0;
		end else begin
			if (element.valid && element.ready) begin
				loaded[load_pos] = element.element_value;
				load_pos = (load_pos + 1) % 16;
				if (load_pos == 0) predict_inverse();
			end
			if (element.valid && !element.ready) begin
				go = 1'b1;
			end else if (pending_elems.size() != 0
					&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
				go = 1'b1;
				element.element_value <= pending_elems.pop_front();
			end else begin
				go = 1'b0;
			end
			element.valid <= go;
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		inv_elem_t x;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("** matrix4_inverse_unit: FAILED **");
				$finish;
			end
			if (result.valid && result.ready) begin
				if (inverse_due.size() == 0) begin
					$error("unexpected result at index %0d", result.result_index);
					errors++;
				end else begin
					x = inverse_due.pop_front();
					if (result.result_value !== x.value) begin
						$error("result_value: expected %h, got %h", x.value, result.result_value);
						errors++;
					end
					if (result.result_index !== x.index) begin
						$error("result_index: expected %0d, got %0d", x.index, result.result_index);
						errors++;
					end
					if (result.singular !== x.singular) begin
						$error("singular: expected %b, got %b", x.singular, result.singular);
						errors++;
					end
					if (result.saturated !== x.saturated) begin
						$error("saturated: expected %b, got %b", x.saturated, result.saturated);
						errors++;
					end
					if (result.last_of_run !== x.last) begin
						$error("last_of_run: expected %b, got %b", x.last, result.last_of_run);
						errors++;
					end
				end
			end
			result.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	function automatic logic signed [m4i_pkg::ELEM_W-1:0] small_val();
		return $signed($urandom_range(8 << FRAC)) - (4 <<< FRAC);
	endfunction

	task automatic queue_matrix(mat_kind_t kind);
		logic signed [m4i_pkg::ELEM_W-1:0] m[16];
		int k;
		for (k = 0; k < 16; k++) begin
			case (kind)
				MAT_WIDE: begin
					m[k] = $urandom;
				end
				MAT_DIAG: begin
					m[k] = ((k >> 2) == (k & 3)) ? small_val() * 4 + (1 <<< FRAC)
						: small_val() >>> $urandom_range(8);
				end
				default: begin
					m[k] = small_val();
				end
			endcase
		end
		if (kind == MAT_SINGULAR)
			for (k = 0; k < 4; k++) m[8 + k] = m[$urandom_range(3)*4 + k];
		for (k = 0; k < 16; k++) pending_elems.push_back(m[k]);
	endtask

	task automatic drain();
		while (pending_elems.size() != 0 || element.valid || inverse_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int k;
		element.valid = 1'b0;
		element.element_value = '0;
		result.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Singular matrix of extreme values in two pairs of equal rows.
		for (k = 0; k < 16; k++) begin
			case (k % 4)
				0: pending_elems.push_back(32'h7FFFFFFF);
				1: pending_elems.push_back(32'h80000000);
				2: pending_elems.push_back(k < 8 ? 32'h00000000 : 32'h00010000);
				default: pending_elems.push_back(k < 8 ? 32'hFFFFFFFF : 32'h00000005);
			endcase
		end
		drain();

		// Tiny diagonal: clipping on both sides and an exact -2^31 quotient.
		for (k = 0; k < 16; k++) begin
			case (k)
				0: pending_elems.push_back(32'sd1);
				5: pending_elems.push_back(-32'sd1);
				10: pending_elems.push_back(-32'sd2);
				15: pending_elems.push_back(32'sd3);
				default: pending_elems.push_back(32'sd0);
			endcase
		end
		drain();

		queue_matrix(MAT_WIDE);
		queue_matrix(MAT_SMALL);
		drain();
		calm = 1'b1;
		queue_matrix(MAT_DIAG);
		drain();
		calm = 1'b0;
		queue_matrix(mat_kind_t'($urandom_range(3)));
		queue_matrix(MAT_SINGULAR);
		drain();
		repeat (300) @(posedge clk);

		$display("Inverted %0d matrices, %0d singular, %0d clipped elements.",
			matrices, singular_seen, clipped_seen);
		if (errors == 0) begin
			$display("** matrix4_inverse_unit: PASSED **");
		end else begin
			$display("** matrix4_inverse_unit: FAILED **");
		end
		$finish;
	end
endmodule
